@@ src/esae_pkg.sv @@
// Shared types, codes and helpers of the encoder speed and acceleration estimator.
`default_nettype none

package esae_pkg;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_POS_SCALE    = 3'd0,
		REG_SAMPLE_RATE  = 3'd1,
		REG_SPEED_GAIN   = 3'd2,
		REG_SPEED_FB_ONE = 3'd3,
		REG_SPEED_FB_TWO = 3'd4,
		REG_ACCEL_GAIN   = 3'd5,
		REG_ACCEL_FB_ONE = 3'd6,
		REG_ACCEL_FB_TWO = 3'd7
	} cfg_idx_t;

	// Datapath operations, in the order the sequencer issues them.
	typedef enum logic [3:0] {
		OP_POS  = 4'd0,
		OP_SRAW = 4'd1,
		OP_SP   = 4'd2,
		OP_SB1  = 4'd3,
		OP_SB2  = 4'd4,
		OP_ARAW = 4'd5,
		OP_AP   = 4'd6,
		OP_AB1  = 4'd7,
		OP_AB2  = 4'd8
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'd0,
		ST_LO   = 3'd1,
		ST_HI   = 3'd2,
		ST_WB   = 3'd3,
		ST_CLR  = 3'd4,
		ST_FIN  = 3'd5
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic clear;
		logic mul_lo;
		logic mul_hi;
		logic wb;
		logic load_out;
		op_t  op;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_mode;
	} status_t;

	localparam int unsigned ACC_W = 82;
	localparam logic signed [ACC_W-1:0] SAT_HI = 82'sd140737488355327;
	localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - 82'sd1;
	localparam logic [31:0] POS_ZERO_SCALE = 32'd32767;

	// Clamp a wide signed value to the signed 48-bit range.
	function automatic logic signed [47:0] sat48(input logic signed [ACC_W-1:0] v);
		logic signed [47:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI[47:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[47:0];
		end else begin
			r = v[47:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ src/encoder_speed_accel_estimator.sv @@
// Top level of the encoder speed and acceleration estimator.
// A sample request (mode 0) computes nine products (position, raw speed, three speed
// filter terms, raw acceleration, three acceleration filter terms) one after another
// through a single shared 25 by 33 bit multiplier, each in two passes plus a
// write-back step; the output register is then loaded once it is free. A new request
// is accepted only when the controller is back in idle, after the output is loaded. A
// position reset request (mode 1) clears the filter history and gives no result. A
// finished result waits in the output register while the next request is already
// being worked on.
`default_nettype none

module encoder_speed_accel_estimator import esae_pkg::*; (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_we,
	input  wire  [2:0]         cfg_index,
	input  wire  [31:0]        cfg_data,
	input  wire                in_valid,
	output logic               in_stall,
	input  wire                mode,
	input  wire  signed [31:0] angle,
	output logic               out_valid,
	input  wire                out_stall,
	output logic signed [31:0] pos_scaled,
	output logic signed [47:0] speed,
	output logic signed [47:0] accel
);

	cmd_t    cmd;
	status_t status;

	esae_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	esae_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mode       (mode),
		.angle      (angle),
		.cmd        (cmd),
		.status     (status),
		.pos_scaled (pos_scaled),
		.speed      (speed),
		.accel      (accel)
	);

endmodule

`default_nettype wire

@@ src/esae_dp.sv @@
// Datapath: configuration, state, shared two-pass multiplier and filter arithmetic.
`default_nettype none

module esae_dp import esae_pkg::*; (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_we,
	input  wire  [2:0]         cfg_index,
	input  wire  [31:0]        cfg_data,
	input  wire                mode,
	input  wire  signed [31:0] angle,
	input  cmd_t               cmd,
	output status_t            status,
	output logic signed [31:0] pos_scaled,
	output logic signed [47:0] speed,
	output logic signed [47:0] accel
);

	logic        [31:0] pos_scale_q;
	logic        [16:0] rate_q;
	logic signed [31:0] sgain_q, sfb1_q, sfb2_q, again_q, afb1_q, afb2_q;

	logic signed [31:0] angle_q;
	logic signed [31:0] prev_angle_q;
	logic signed [47:0] prev_speed_q, spd_raw_q, acc_raw_q;
	logic signed [47:0] d1_q [2];
	logic signed [47:0] d2_q [2];
	logic signed [51:0] p_q;
	logic signed [47:0] ys_q, ya_q;
	logic signed [31:0] pos_q;
	logic signed [ACC_W-1:0] acc_q;

	logic signed [48:0] x;
	logic signed [32:0] c;
	logic signed [24:0] a25;
	logic signed [57:0] prod;
	logic signed [32:0] angle_diff;
	logic signed [32:0] angle_mag;
	logic signed [51:0] m;
	logic        [31:0] q;
	logic               sel;

	assign status.in_mode = mode;

	// Configuration register file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_scale_q <= 32'd11930283;
			rate_q      <= 17'd1000;
			sgain_q     <= '0;
			sfb1_q      <= '0;
			sfb2_q      <= '0;
			again_q     <= '0;
			afb1_q      <= '0;
			afb2_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_POS_SCALE:    pos_scale_q <= cfg_data;
				REG_SAMPLE_RATE:  rate_q      <= cfg_data[16:0];
				REG_SPEED_GAIN:   sgain_q     <= cfg_data;
				REG_SPEED_FB_ONE: sfb1_q      <= cfg_data;
				REG_SPEED_FB_TWO: sfb2_q      <= cfg_data;
				REG_ACCEL_GAIN:   again_q     <= cfg_data;
				REG_ACCEL_FB_ONE: afb1_q      <= cfg_data;
				REG_ACCEL_FB_TWO: afb2_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Operand selection for the current operation.
	assign angle_diff = 33'(angle_q) - 33'(prev_angle_q);
	assign angle_mag  = angle_q[31] ? -33'(angle_q) : 33'(angle_q);

	always_comb begin
		x = 49'(angle_mag);
		c = {1'b0, pos_scale_q};
		case (cmd.op)
			OP_POS: begin
				x = 49'(angle_mag);
				c = {1'b0, pos_scale_q};
			end
			OP_SRAW: begin
				x = 49'(angle_diff);
				c = {16'd0, rate_q};
			end
			OP_SP: begin
				x = 49'(spd_raw_q);
				c = 33'(sgain_q);
			end
			OP_SB1: begin
				x = 49'(ys_q);
				c = 33'(sfb1_q);
			end
			OP_SB2: begin
				x = 49'(ys_q);
				c = 33'(sfb2_q);
			end
			OP_ARAW: begin
				x = 49'(spd_raw_q) - 49'(prev_speed_q);
				c = {16'd0, rate_q};
			end
			OP_AP: begin
				x = 49'(acc_raw_q);
				c = 33'(again_q);
			end
			OP_AB1: begin
				x = 49'(ya_q);
				c = 33'(afb1_q);
			end
			OP_AB2: begin
				x = 49'(ya_q);
				c = 33'(afb2_q);
			end
			default: ;
		endcase
	end

	// Shared multiplier: low 24 bits of the operand first, then the signed high part.
	assign a25  = cmd.mul_hi ? x[48:24] : $signed({1'b0, x[23:0]});
	assign prod = a25 * c;

	always_ff @(posedge clk) begin
		if (cmd.mul_lo) begin
			acc_q <= ACC_W'(prod);
		end else if (cmd.mul_hi) begin
			acc_q <= acc_q + $signed({prod, 24'd0});
		end
	end

	// Product scaled down by 2^30 (m) and by 2^32 (q), rounded toward minus infinity.
	assign m   = acc_q[81:30];
	assign q   = acc_q[63:32];
	assign sel = (cmd.op == OP_AP) || (cmd.op == OP_AB1) || (cmd.op == OP_AB2);

	// Input capture and payload results.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			angle_q <= angle;
		end
		if (cmd.wb) begin
			case (cmd.op)
				OP_POS: begin
					if (pos_scale_q == 32'd0) begin
						pos_q <= POS_ZERO_SCALE;
					end else begin
						pos_q <= angle_q[31] ? -q : q;
					end
				end
				OP_SRAW: spd_raw_q <= sat48(acc_q);
				OP_SP: begin
					p_q  <= m;
					ys_q <= sat48(ACC_W'(m) + ACC_W'(d1_q[0]));
				end
				OP_ARAW: acc_raw_q <= sat48(acc_q);
				OP_AP: begin
					p_q  <= m;
					ya_q <= sat48(ACC_W'(m) + ACC_W'(d1_q[1]));
				end
				default: ;
			endcase
		end
		if (cmd.load_out) begin
			pos_scaled <= pos_q;
			speed      <= ys_q;
			accel      <= ya_q;
		end
	end

	// Delays and history, cleared by reset; a position reset clears all but the angle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_angle_q <= '0;
			prev_speed_q <= '0;
			d1_q[0]      <= '0;
			d1_q[1]      <= '0;
			d2_q[0]      <= '0;
			d2_q[1]      <= '0;
		end else if (cmd.clear) begin
			prev_angle_q <= angle_q;
			prev_speed_q <= '0;
			d1_q[0]      <= '0;
			d1_q[1]      <= '0;
			d2_q[0]      <= '0;
			d2_q[1]      <= '0;
		end else if (cmd.wb) begin
			case (cmd.op)
				OP_SB1, OP_AB1: begin
					d1_q[sel] <= sat48(ACC_W'(p_q) + ACC_W'(p_q) + ACC_W'(d2_q[sel])
						- ACC_W'(m));
				end
				OP_SB2, OP_AB2: begin
					d2_q[sel] <= sat48(ACC_W'(p_q) - ACC_W'(m));
				end
				OP_ARAW: begin
					prev_speed_q <= spd_raw_q;
					prev_angle_q <= angle_q;
				end
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	// A position reset leaves the filter delays at zero (checked on d1_q[0] and d2_q[1]).
	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (d1_q[0] == 48'sd0) && (d2_q[1] == 48'sd0))
		else $error("filter delays not cleared");
	// The multiplier never runs both passes at once.
	a_one_pass: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.mul_lo && cmd.mul_hi))
		else $error("both multiplier passes requested");
	// A zero scale always yields the fixed position code.
	a_zero_scale: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wb && cmd.op == OP_POS && pos_scale_q == 32'd0) |=> pos_q == POS_ZERO_SCALE)
		else $error("zero scale position wrong");
`endif

endmodule

`default_nettype wire

@@ src/esae_ctrl.sv @@
// Controller: sequences the shared multiplier through one sample and owns the handshakes.
`default_nettype none

module esae_ctrl import esae_pkg::*; (
	input  wire     clk,
	input  wire     arst_n,
	input  wire     in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  wire     out_stall,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;
	op_t    op_q, op_d;
	logic   out_valid_d;

	// State, operation and output valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			op_q      <= OP_POS;
			out_valid <= 1'b0;
		end else begin
			state_q   <= state_d;
			op_q      <= op_d;
			out_valid <= out_valid_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d     = state_q;
		op_d        = op_q;
		out_valid_d = out_valid && out_stall;
		in_stall    = 1'b1;
		cmd         = '0;
		cmd.op      = op_q;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					op_d        = OP_POS;
					state_d     = status.in_mode ? ST_CLR : ST_LO;
				end
			end
			ST_LO: begin
				cmd.mul_lo = 1'b1;
				state_d    = ST_HI;
			end
			ST_HI: begin
				cmd.mul_hi = 1'b1;
				state_d    = ST_WB;
			end
			ST_WB: begin
				cmd.wb = 1'b1;
				if (op_q == OP_AB2) begin
					state_d = ST_FIN;
				end else begin
					op_d    = op_t'(op_q + 4'd1);
					state_d = ST_LO;
				end
			end
			ST_CLR: begin
				cmd.clear = 1'b1;
				state_d   = ST_IDLE;
			end
			ST_FIN: begin
				if (!out_valid || !out_stall) begin
					cmd.load_out = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

`ifndef SYNTHESIS
	// A result appears only when a sample finishes its sequence.
	a_rise_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_FIN)
		else $error("result raised outside finish");
	// A position reset item never produces a result.
	a_clr_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLR |=> !$rose(out_valid))
		else $error("result after position reset");
	// Work in flight blocks new requests.
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LO || state_q == ST_HI || state_q == ST_WB) |-> in_stall)
		else $error("request taken while busy");
`endif

endmodule

`default_nettype wire
